FILE: src/sfa_pkg.sv
package sfa_pkg;

    localparam int FRAME_SLOTS = 64;
    localparam int SLOT_W      = $clog2(FRAME_SLOTS);
    localparam int TILE_SIZE   = 32;

    localparam int ACC_W       = 24;
    localparam int PERIOD_W    = 16;
    localparam int STEP_W      = 16;
    localparam int POS_W       = 6;
    localparam int LEN_W       = 7;
    localparam int MAX_LEN     = 64;
    localparam int COORD_W     = 8;
    localparam int RECT_POS_W  = 13;
    localparam int RECT_DIM_W  = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_PERIOD    = 3'd0,
        CFG_LOOP_ENABLE     = 3'd1,
        CFG_PINGPONG_ENABLE = 3'd2,
        CFG_SEQUENCE_START  = 3'd3,
        CFG_SEQUENCE_LENGTH = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic               mirror;
        logic               double_height;
        logic               double_width;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } frame_entry_t;

endpackage

FILE: src/sprite_frame_animator.sv
// Sprite frame animator.
// Input channel (in_valid/in_stall) carries one command per transfer: a tick
// with time_step, a frame store write (entry_*), or a restart. A tick adds
// time_step to a saturating elapsed-time accumulator; when it reaches
// frame_period the period is subtracted and the frame position steps once
// within the active range (wrap, clamp or ping-pong). Such a tick yields one
// result transfer on the output channel (out_valid/out_stall) with the frame
// number and texture rectangle of the new frame; other commands yield none.
// Configuration registers are written over cfg_valid/cfg_ready/cfg_index/
// cfg_data, always ready; write them only while the block is idle.
// A tick's result is registered in the read stage (the control update and frame
// store read register at the transfer edge), then in the output register once
// that register is free to take it.
// Throughput: one command per cycle while in_stall is low; the frame store has
// one write and one registered read port.
// Reset clears configuration to defaults, the accumulator, position and
// direction; frame store contents are undefined until written.
// When the receiver stalls, the output register holds, the read stage fills,
// and in_stall rises until the output moves again.
module sprite_frame_animator (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfa_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        command,
    input  logic [sfa_pkg::STEP_W-1:0]        time_step,
    input  logic [sfa_pkg::SLOT_W-1:0]        entry_index,
    input  logic [sfa_pkg::COORD_W-1:0]       entry_col,
    input  logic [sfa_pkg::COORD_W-1:0]       entry_row,
    input  logic                              entry_double_width,
    input  logic                              entry_double_height,
    input  logic                              entry_mirror,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sfa_pkg::POS_W-1:0]         frame_number,
    output logic [sfa_pkg::RECT_POS_W-1:0]    rect_x,
    output logic [sfa_pkg::RECT_POS_W-1:0]    rect_y,
    output logic [sfa_pkg::RECT_DIM_W-1:0]    rect_width,
    output logic [sfa_pkg::RECT_DIM_W-1:0]    rect_height,
    output logic                              mirror
);

    // configuration
    logic [sfa_pkg::PERIOD_W-1:0] period_reg;
    logic                         loop_reg;
    logic                         pingpong_reg;
    logic [sfa_pkg::POS_W-1:0]    start_reg;
    logic [sfa_pkg::LEN_W-1:0]    length_reg;

    // animation state
    logic [sfa_pkg::ACC_W-1:0]    acc_reg,  acc_next;
    logic [sfa_pkg::POS_W-1:0]    pos_reg,  pos_next;
    logic                         back_reg, back_next;

    // read stage and output stage
    logic                         s1_valid_reg, s1_valid_next;
    logic [sfa_pkg::POS_W-1:0]    s1_pos_reg;
    sfa_pkg::frame_entry_t        rd_entry_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [sfa_pkg::POS_W-1:0]    out_pos_reg;
    sfa_pkg::frame_entry_t        out_entry_reg;

    sfa_pkg::frame_entry_t        store_mem [sfa_pkg::FRAME_SLOTS];

    logic                         in_acc;
    logic                         s1_move;
    logic                         is_tick;
    logic                         advance;
    logic [sfa_pkg::ACC_W:0]      acc_sum;
    logic [sfa_pkg::ACC_W-1:0]    acc_sat;
    logic [sfa_pkg::LEN_W-1:0]    len;
    logic [sfa_pkg::POS_W-1:0]    len_m1;
    logic                         dir_back;
    logic [sfa_pkg::POS_W-1:0]    step_pos;
    logic [sfa_pkg::SLOT_W-1:0]   rd_addr;
    logic [sfa_pkg::SLOT_W-1:0]   wr_addr;
    sfa_pkg::frame_entry_t        wr_entry;

    assign cfg_ready = 1'b1;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_acc   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= sfa_pkg::PERIOD_RESET;
            loop_reg     <= 1'b1;
            pingpong_reg <= 1'b0;
            start_reg    <= '0;
            length_reg   <= sfa_pkg::LEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sfa_pkg::CFG_FRAME_PERIOD:    period_reg   <= cfg_data[sfa_pkg::PERIOD_W-1:0];
                sfa_pkg::CFG_LOOP_ENABLE:     loop_reg     <= cfg_data[0];
                sfa_pkg::CFG_PINGPONG_ENABLE: pingpong_reg <= cfg_data[0];
                sfa_pkg::CFG_SEQUENCE_START:  start_reg    <= cfg_data[sfa_pkg::POS_W-1:0];
                sfa_pkg::CFG_SEQUENCE_LENGTH: length_reg   <= cfg_data[sfa_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // accumulate, saturate, compare
    assign is_tick = (command == sfa_pkg::CMD_TICK);
    assign acc_sum = {1'b0, acc_reg} + {{(sfa_pkg::ACC_W + 1 - sfa_pkg::STEP_W){1'b0}}, time_step};
    assign acc_sat = acc_sum[sfa_pkg::ACC_W] ? {sfa_pkg::ACC_W{1'b1}}
                                             : acc_sum[sfa_pkg::ACC_W-1:0];
    assign advance = in_acc && is_tick &&
                     (acc_sat >= {{(sfa_pkg::ACC_W - sfa_pkg::PERIOD_W){1'b0}}, period_reg});

    // active range length clamped to 1..64
    always_comb
    begin
        if (length_reg == '0)
            len = sfa_pkg::LEN_W'(1);
        else if (length_reg > sfa_pkg::LEN_W'(sfa_pkg::MAX_LEN))
            len = sfa_pkg::LEN_W'(sfa_pkg::MAX_LEN);
        else
            len = length_reg;
    end
    assign len_m1 = sfa_pkg::POS_W'(len - sfa_pkg::LEN_W'(1));

    // position step
    always_comb
    begin
        dir_back = back_reg;
        if (pingpong_reg)
        begin
            if (!back_reg && pos_reg >= len_m1)
                dir_back = 1'b1;
            else if (back_reg && pos_reg == '0)
                dir_back = 1'b0;
        end

        if (dir_back)
        begin
            if (pos_reg == '0)
                step_pos = loop_reg ? len_m1 : '0;
            else if (pos_reg - sfa_pkg::POS_W'(1) > len_m1)
                step_pos = len_m1;
            else
                step_pos = pos_reg - sfa_pkg::POS_W'(1);
        end
        else
        begin
            if (pos_reg >= len_m1)
                step_pos = loop_reg ? '0 : len_m1;
            else
                step_pos = pos_reg + sfa_pkg::POS_W'(1);
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        pos_next  = pos_reg;
        back_next = back_reg;
        if (in_acc)
        begin
            case (command)
                sfa_pkg::CMD_TICK:
                begin
                    if (advance)
                    begin
                        acc_next  = acc_sat - {{(sfa_pkg::ACC_W - sfa_pkg::PERIOD_W){1'b0}},
                                               period_reg};
                        pos_next  = step_pos;
                        back_next = dir_back;
                    end
                    else
                        acc_next = acc_sat;
                end
                sfa_pkg::CMD_RESTART:
                begin
                    acc_next = '0;
                    pos_next = '0;
                end
                default: ;
            endcase
        end
    end

    assign rd_addr = sfa_pkg::SLOT_W'(start_reg + step_pos);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
            s1_valid_next = advance;
        else if (s1_move)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_move)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pos_reg       <= '0;
            back_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            back_reg      <= back_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // frame store: one write port, one registered read port
    assign wr_addr  = sfa_pkg::SLOT_W'(entry_index);
    assign wr_entry = '{mirror:        entry_mirror,
                        double_height: entry_double_height,
                        double_width:  entry_double_width,
                        row:           entry_row,
                        col:           entry_col};

    always_ff @(posedge clk)
    begin
        if (in_acc && command == sfa_pkg::CMD_WRITE)
            store_mem[wr_addr] <= wr_entry;
        if (advance)
            rd_entry_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            s1_pos_reg <= step_pos;
        if (s1_move)
        begin
            out_pos_reg   <= s1_pos_reg;
            out_entry_reg <= rd_entry_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_number = out_pos_reg;
    assign rect_x       = sfa_pkg::RECT_POS_W'(out_entry_reg.col * sfa_pkg::TILE_SIZE);
    assign rect_y       = sfa_pkg::RECT_POS_W'(out_entry_reg.row * sfa_pkg::TILE_SIZE);
    assign rect_width   = out_entry_reg.double_width
                        ? sfa_pkg::RECT_DIM_W'(2 * sfa_pkg::TILE_SIZE)
                        : sfa_pkg::RECT_DIM_W'(sfa_pkg::TILE_SIZE);
    assign rect_height  = out_entry_reg.double_height
                        ? sfa_pkg::RECT_DIM_W'(2 * sfa_pkg::TILE_SIZE)
                        : sfa_pkg::RECT_DIM_W'(sfa_pkg::TILE_SIZE);
    assign mirror       = out_entry_reg.mirror;

endmodule

FILE: bench/tb_sprite_frame_animator.sv
module tb_sprite_frame_animator;
    import sfa_pkg::*;

    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam int unsigned ACC_MAX      = 24'hFFFFFF;
    localparam int          IDLE_CYCLES  = 4;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [1:0]         command;
        logic [STEP_W-1:0]  time_step;
        logic [SLOT_W-1:0]  entry_index;
        logic [COORD_W-1:0] entry_col;
        logic [COORD_W-1:0] entry_row;
        logic               entry_double_width;
        logic               entry_double_height;
        logic               entry_mirror;
    } anim_cmd_t;

    localparam int CMD_BITS = $bits(anim_cmd_t);

    typedef struct packed {
        logic [POS_W-1:0]      frame_number;
        logic [RECT_POS_W-1:0] rect_x;
        logic [RECT_POS_W-1:0] rect_y;
        logic [RECT_DIM_W-1:0] rect_width;
        logic [RECT_DIM_W-1:0] rect_height;
        logic                  mirror;
    } frame_rect_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             command;
    logic [STEP_W-1:0]      time_step;
    logic [SLOT_W-1:0]      entry_index;
    logic [COORD_W-1:0]     entry_col;
    logic [COORD_W-1:0]     entry_row;
    logic                   entry_double_width;
    logic                   entry_double_height;
    logic                   entry_mirror;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [POS_W-1:0]       frame_number;
    logic [RECT_POS_W-1:0]  rect_x;
    logic [RECT_POS_W-1:0]  rect_y;
    logic [RECT_DIM_W-1:0]  rect_width;
    logic [RECT_DIM_W-1:0]  rect_height;
    logic                   mirror;

    // animator shadow state
    logic [PERIOD_W-1:0]    period_m;
    logic                   loop_m;
    logic                   pingpong_m;
    logic [POS_W-1:0]       start_m;
    logic [LEN_W-1:0]       length_m;
    logic [ACC_W-1:0]       acc_m;
    logic [POS_W-1:0]       pos_m;
    logic                   backward_m;
    frame_entry_t           store_m [FRAME_SLOTS];

    frame_rect_t            expected_frames [$];
    frame_rect_t            got_frame;
    frame_rect_t            want_frame;
    int unsigned            fail_count = 0;
    int unsigned            cycle_count = 0;
    int unsigned            send_idle_pct = 0;
    int unsigned            stall_pct = 0;

    sprite_frame_animator u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .command             (command),
        .time_step           (time_step),
        .entry_index         (entry_index),
        .entry_col           (entry_col),
        .entry_row           (entry_row),
        .entry_double_width  (entry_double_width),
        .entry_double_height (entry_double_height),
        .entry_mirror        (entry_mirror),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .frame_number        (frame_number),
        .rect_x              (rect_x),
        .rect_y              (rect_y),
        .rect_width          (rect_width),
        .rect_height         (rect_height),
        .mirror              (mirror)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_frame = '{frame_number: frame_number, rect_x: rect_x, rect_y: rect_y,
                          rect_width: rect_width, rect_height: rect_height,
                          mirror: mirror};
            if (expected_frames.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: frame %0d rect %0d,%0d %0dx%0d mirror %0d",
                             got_frame.frame_number, got_frame.rect_x, got_frame.rect_y,
                             got_frame.rect_width, got_frame.rect_height, got_frame.mirror);
            end
            else
            begin
                want_frame = expected_frames.pop_front();
                if (got_frame.frame_number !== want_frame.frame_number ||
                    got_frame.rect_x !== want_frame.rect_x ||
                    got_frame.rect_y !== want_frame.rect_y ||
                    got_frame.rect_width !== want_frame.rect_width ||
                    got_frame.rect_height !== want_frame.rect_height ||
                    got_frame.mirror !== want_frame.mirror)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $write("mismatch: expected frame %0d rect %0d,%0d %0dx%0d mirror %0d, ",
                               want_frame.frame_number, want_frame.rect_x,
                               want_frame.rect_y, want_frame.rect_width,
                               want_frame.rect_height, want_frame.mirror);
                        $display("got frame %0d rect %0d,%0d %0dx%0d mirror %0d",
                                 got_frame.frame_number, got_frame.rect_x, got_frame.rect_y,
                                 got_frame.rect_width, got_frame.rect_height,
                                 got_frame.mirror);
                    end
                end
            end
        end
    end

    function automatic void apply_register(input cfg_idx_t idx, input logic [15:0] d);
        case (idx)
            CFG_FRAME_PERIOD:    period_m   = d[PERIOD_W-1:0];
            CFG_LOOP_ENABLE:     loop_m     = d[0];
            CFG_PINGPONG_ENABLE: pingpong_m = d[0];
            CFG_SEQUENCE_START:  start_m    = d[POS_W-1:0];
            CFG_SEQUENCE_LENGTH: length_m   = d[LEN_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void animate_step(input anim_cmd_t c);
        int unsigned  sum;
        int           len;
        int           p;
        int           nxt;
        frame_entry_t e;
        frame_rect_t  r;
        case (c.command)
            CMD_WRITE:
                store_m[c.entry_index] = '{mirror: c.entry_mirror,
                                           double_height: c.entry_double_height,
                                           double_width: c.entry_double_width,
                                           row: c.entry_row, col: c.entry_col};
            CMD_RESTART:
            begin
                acc_m = '0;
                pos_m = '0;
            end
            CMD_TICK:
            begin
                sum = int'(acc_m) + int'(c.time_step);
                if (sum > ACC_MAX)
                    sum = ACC_MAX;
                acc_m = ACC_W'(sum);
                if (acc_m >= ACC_W'(period_m))
                begin
                    acc_m = acc_m - ACC_W'(period_m);
                    len = int'(length_m);
                    if (len < 1)
                        len = 1;
                    if (len > MAX_LEN)
                        len = MAX_LEN;
                    p = int'(pos_m);
                    if (pingpong_m)
                    begin
                        if (!backward_m && p >= len - 1)
                            backward_m = 1'b1;
                        else if (backward_m && p == 0)
                            backward_m = 1'b0;
                    end
                    nxt = backward_m ? p - 1 : p + 1;
                    if (nxt < 0 || nxt >= len)
                    begin
                        if (loop_m)
                            nxt = backward_m ? len - 1 : 0;
                        else if (nxt < 0)
                            nxt = 0;
                        else
                            nxt = len - 1;
                    end
                    pos_m = POS_W'(nxt);
                    e = store_m[SLOT_W'(int'(start_m) + int'(pos_m))];
                    r.frame_number = pos_m;
                    r.rect_x       = RECT_POS_W'(int'(e.col) * TILE_SIZE);
                    r.rect_y       = RECT_POS_W'(int'(e.row) * TILE_SIZE);
                    r.rect_width   = e.double_width ? RECT_DIM_W'(2 * TILE_SIZE)
                                                    : RECT_DIM_W'(TILE_SIZE);
                    r.rect_height  = e.double_height ? RECT_DIM_W'(2 * TILE_SIZE)
                                                     : RECT_DIM_W'(TILE_SIZE);
                    r.mirror       = e.mirror;
                    expected_frames.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic anim_cmd_t make_cmd(input logic [1:0] code);
        anim_cmd_t c;
        c = anim_cmd_t'(CMD_BITS'({$urandom, $urandom}));
        c.command = code;
        return c;
    endfunction

    function automatic anim_cmd_t make_tick(input logic [STEP_W-1:0] step);
        anim_cmd_t c;
        c = make_cmd(CMD_TICK);
        c.time_step = step;
        return c;
    endfunction

    function automatic anim_cmd_t random_cmd();
        anim_cmd_t   c;
        int unsigned r;
        int unsigned hi;
        r = $urandom_range(0, 99);
        hi = 2 * int'(period_m) + 1;
        if (hi > 65535)
            hi = 65535;
        if (r < 8)
            c = make_cmd(CMD_WRITE);
        else if (r < 12)
            c = make_cmd(CMD_RESTART);
        else if (r < 15)
            c = make_cmd(CMD_UNUSED);
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                c = make_tick(STEP_W'($urandom_range(0, hi)));
            else if (r < 85)
                c = make_tick(STEP_W'($urandom));
            else if (r < 92)
                c = make_tick('0);
            else
                c = make_tick('1);
        end
        return c;
    endfunction

    function automatic int unsigned pick_period();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        else if (r < 15)
            return 1;
        else if (r < 25)
            return 65535;
        else if (r < 40)
            return $urandom_range(2, 20);
        return $urandom_range(21, 2000);
    endfunction

    function automatic int unsigned pick_length(input int unsigned max_len);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        else if (r < 10)
            return 1;
        else if (r < 15)
            return MAX_LEN;
        else if (r < 20)
            return $urandom_range(MAX_LEN + 1, 127);
        return $urandom_range(2, max_len);
    endfunction

    task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // one transfer on the command channel; entered and left at a falling edge
    task automatic send_cmd(input anim_cmd_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid            <= 1'b1;
        command             <= c.command;
        time_step           <= c.time_step;
        entry_index         <= c.entry_index;
        entry_col           <= c.entry_col;
        entry_row           <= c.entry_row;
        entry_double_width  <= c.entry_double_width;
        entry_double_height <= c.entry_double_height;
        entry_mirror        <= c.entry_mirror;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        animate_step(c);
        @(negedge clk);
    endtask

    // drain the block, then write all five registers
    task automatic reconfigure(input int unsigned period, input bit loop_on,
                               input bit pp_on, input int unsigned start,
                               input int unsigned len);
        cfg_idx_t    regs [5] = '{CFG_FRAME_PERIOD, CFG_LOOP_ENABLE, CFG_PINGPONG_ENABLE,
                                  CFG_SEQUENCE_START, CFG_SEQUENCE_LENGTH};
        logic [15:0] data [5];
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(negedge clk);
        repeat (IDLE_CYCLES) @(negedge clk);
        data[0] = period[15:0];
        data[1] = {15'($urandom), loop_on};
        data[2] = {15'($urandom), pp_on};
        data[3] = {10'($urandom), start[5:0]};
        data[4] = {9'($urandom), len[6:0]};
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= data[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            apply_register(regs[i], data[i]);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int count);
        int        sent;
        anim_cmd_t c;
        sent = 0;
        while (sent < count)
        begin
            c = random_cmd();
            send_cmd(c);
            if (c.command != CMD_UNUSED)
                sent++;
        end
    endtask

    task automatic run_phase(input int unsigned period, input bit loop_on, input bit pp_on,
                             input int unsigned start, input int unsigned len,
                             input int count);
        reconfigure(period, loop_on, pp_on, start, len);
        random_traffic(count);
    endtask

    // every slot gets written before any tick can read it
    task automatic test_fill_store();
        anim_cmd_t c;
        set_idle(0, 0);
        for (int i = 0; i < FRAME_SLOTS; i++)
        begin
            c = make_cmd(CMD_WRITE);
            c.entry_index = SLOT_W'(i);
            if (i == 0)
                {c.entry_col, c.entry_row, c.entry_double_width,
                 c.entry_double_height, c.entry_mirror} = '1;
            else if (i == FRAME_SLOTS - 1)
                {c.entry_col, c.entry_row, c.entry_double_width,
                 c.entry_double_height, c.entry_mirror} = '0;
            send_cmd(c);
        end
    endtask

    task automatic test_directed();
        set_idle(0, 0);
        // reset settings: period 1000, one-frame looping range
        send_cmd(make_tick(16'd0));
        send_cmd(make_tick(16'd999));
        send_cmd(make_tick(16'd1));
        send_cmd(make_cmd(CMD_UNUSED));
        send_cmd(make_cmd(CMD_RESTART));
        // zero period, zero length, top slot
        reconfigure(0, 1'b1, 1'b0, 63, 0);
        send_cmd(make_tick(16'd0));
        // oversized length, clamping, slot index wraps
        reconfigure(1, 1'b0, 1'b0, 60, 127);
        repeat (5) send_cmd(make_tick(16'hFFFF));
        // range shrunk below the position
        reconfigure(65535, 1'b0, 1'b0, 60, 3);
        send_cmd(make_tick(16'hFFFF));
        reconfigure(65535, 1'b1, 1'b0, 0, 2);
        send_cmd(make_tick(16'hFFFF));
        // ping-pong turn at the last frame
        reconfigure(1, 1'b1, 1'b1, 0, 3);
        send_cmd(make_cmd(CMD_RESTART));
        repeat (3) send_cmd(make_tick(16'd1));
        // ping-pong off while moving backward
        reconfigure(1, 1'b1, 1'b0, 0, 3);
        repeat (2) send_cmd(make_tick(16'd1));
        // one-frame ping-pong range
        reconfigure(1, 1'b1, 1'b1, 5, 1);
        repeat (2) send_cmd(make_tick(16'd1));
    endtask

    task automatic test_loop_mode();
        set_idle(0, 0);
        repeat (4)
            run_phase(pick_period(), 1'b1, 1'b0, $urandom_range(0, 63), pick_length(64), 50);
    endtask

    task automatic test_clamp_mode();
        set_idle(72, 0);
        repeat (4)
            run_phase(pick_period(), 1'b0, 1'b0, $urandom_range(0, 63), pick_length(64), 50);
    endtask

    task automatic test_pingpong();
        set_idle(0, 72);
        repeat (4)
            run_phase(pick_period(), 1'($urandom_range(0, 1)), 1'b1, $urandom_range(0, 63),
                      pick_length(8), 60);
    endtask

    // no restart between settings, so the position often lies past a new range
    task automatic test_mixed_settings();
        set_idle(18, 18);
        repeat (5)
            run_phase(pick_period(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 63), pick_length(64), 50);
    endtask

    task automatic test_saturation();
        set_idle(18, 18);
        reconfigure(0, 1'b1, 1'b0, $urandom_range(0, 63), 8);
        repeat (270) send_cmd(make_tick(16'hFFFF));
        reconfigure(1, 1'b0, 1'b1, $urandom_range(0, 63), 5);
        repeat (10) send_cmd(make_tick(16'hFFFF));
        reconfigure(65535, 1'b1, 1'b1, $urandom_range(0, 63), 6);
        repeat (30) send_cmd(make_tick(16'd0));
        random_traffic(30);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_valid           = 1'b0;
        cfg_index           = CFG_FRAME_PERIOD;
        cfg_data            = '0;
        in_valid            = 1'b0;
        command             = CMD_TICK;
        time_step           = '0;
        entry_index         = '0;
        entry_col           = '0;
        entry_row           = '0;
        entry_double_width  = 1'b0;
        entry_double_height = 1'b0;
        entry_mirror        = 1'b0;

        period_m   = PERIOD_RESET;
        loop_m     = 1'b1;
        pingpong_m = 1'b0;
        start_m    = '0;
        length_m   = LEN_W'(1);
        acc_m      = '0;
        pos_m      = '0;
        backward_m = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_fill_store();
        test_directed();
        test_loop_mode();
        test_clamp_mode();
        test_pingpong();
        test_mixed_settings();
        test_saturation();

        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
